>>> rtl/core/assert_macros.svh
// assertion macros for the point reprojection error checker
// depends on clk and arst_n being visible where the macros are used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge, off while reset is asserted
`define PRE_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check an implication that starts at one edge and ends at the next
`define PRE_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/pre_pkg.sv
// shared types, constants and helpers for the point reprojection error block
// no dependencies
package pre_pkg;

	localparam int MW   = 35;
	localparam int PW   = 2 * MW;
	localparam int RW   = 58;
	localparam int NUMW = 86;
	localparam int DIVN = 86;
	localparam int QW   = 42;
	localparam int DCW  = 7;

	localparam logic [QW-1:0] PROJ_CAP = 42'h100_0000_0000;
	localparam logic signed [MW-1:0] ONE_Q = 35'sd268435456;
	localparam logic [62:0] SUM_MAX = {63{1'b1}};

	localparam logic [2:0] CFG_QUAT_X = 3'd0;
	localparam logic [2:0] CFG_QUAT_Y = 3'd1;
	localparam logic [2:0] CFG_QUAT_Z = 3'd2;
	localparam logic [2:0] CFG_QUAT_W = 3'd3;
	localparam logic [2:0] CFG_TRANS_X = 3'd4;
	localparam logic [2:0] CFG_TRANS_Y = 3'd5;
	localparam logic [2:0] CFG_TRANS_Z = 3'd6;
	localparam logic [2:0] CFG_FOCAL = 3'd7;

	typedef enum logic [4:0] {
		M_XX, M_YY, M_ZZ, M_WW, M_XY, M_XZ, M_YZ, M_WX, M_WY, M_WZ,
		M_R00, M_R01, M_R02, M_R10, M_R11, M_R12, M_R20, M_R21, M_R22,
		M_FXL, M_FXH, M_FYL, M_FYH, M_SQX, M_SQY
	} mstep_t;

	typedef enum logic [3:0] {
		S_IDLE, S_MUL, S_DRAIN, S_DIVLD, S_DIV, S_ERR, S_SQ, S_SQD, S_FIN
	} state_t;

	typedef struct packed {
		logic   load_in;
		logic   mul_en;
		mstep_t mstep;
		logic   div_load;
		logic   div_step;
		logic   err_load;
		logic   out_load;
	} cmd_t;

	function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
		if (v > 44'sd2147483647) begin
			return 32'sh7fff_ffff;
		end else if (v < -44'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic logic [RW-1:0] mag_r(input logic signed [RW-1:0] v);
		return v[RW-1] ? RW'(-v) : RW'(v);
	endfunction

endpackage

>>> rtl/core/pre_div.sv
// two-lane restoring divider, one quotient bit per step, shared divisor
// quotient saturates at the projection cap; depends on pre_pkg
module pre_div (
	input  logic                      clk,
	input  logic                      load,
	input  logic                      step,
	input  logic [pre_pkg::NUMW-1:0]  num_a,
	input  logic [pre_pkg::NUMW-1:0]  num_b,
	input  logic [pre_pkg::RW-1:0]    den,
	output logic [pre_pkg::QW-1:0]    quo_a,
	output logic [pre_pkg::QW-1:0]    quo_b
);
	import pre_pkg::*;

	logic [NUMW-1:0] num_q [2];
	logic [RW-1:0]   rem_q [2];
	logic [QW-1:0]   quo_q [2];
	logic            sat_q [2];
	logic [RW-1:0]   den_q;
	logic [RW:0]     rem2 [2];
	logic            ge [2];
	logic [QW-1:0]   qn [2];

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			rem2[i] = {rem_q[i], num_q[i][NUMW-1]};
			ge[i]   = rem2[i] >= {1'b0, den_q};
			qn[i]   = {quo_q[i][QW-2:0], ge[i]};
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			num_q[0] <= num_a;
			num_q[1] <= num_b;
			den_q    <= den;
			for (int i = 0; i < 2; i++) begin
				rem_q[i] <= '0;
				quo_q[i] <= '0;
				sat_q[i] <= 1'b0;
			end
		end else if (step) begin
			for (int i = 0; i < 2; i++) begin
				num_q[i] <= num_q[i] << 1;
				rem_q[i] <= ge[i] ? RW'(rem2[i] - {1'b0, den_q}) : rem2[i][RW-1:0];
				if (!sat_q[i]) begin
					quo_q[i] <= qn[i];
					if (qn[i] > PROJ_CAP) begin
						sat_q[i] <= 1'b1;
					end
				end
			end
		end
	end

	assign quo_a = sat_q[0] ? PROJ_CAP : quo_q[0];
	assign quo_b = sat_q[1] ? PROJ_CAP : quo_q[1];

endmodule

>>> rtl/core/pre_dp.sv
// datapath: rotation matrix, transform, projection, errors and squared sum
// shared registered multiplier plus pre_div; depends on pre_pkg
module pre_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  pre_pkg::cmd_t       cmd,
	input  logic signed [15:0]  quat_x,
	input  logic signed [15:0]  quat_y,
	input  logic signed [15:0]  quat_z,
	input  logic signed [15:0]  quat_w,
	input  logic signed [31:0]  trans_x,
	input  logic signed [31:0]  trans_y,
	input  logic signed [31:0]  trans_z,
	input  logic [15:0]         focal_length,
	input  logic signed [31:0]  obj_x,
	input  logic signed [31:0]  obj_y,
	input  logic signed [31:0]  obj_z,
	input  logic signed [31:0]  meas_x,
	input  logic signed [31:0]  meas_y,
	input  logic                last_point,
	output logic signed [31:0]  err_x,
	output logic signed [31:0]  err_y,
	output logic [62:0]         sum_sq_err,
	output logic                set_done,
	output logic                depth_fault
);
	import pre_pkg::*;

	logic signed [31:0]   p_q [3];
	logic signed [31:0]   meas_x_q, meas_y_q;
	logic                 last_q;
	logic signed [31:0]   qp_q [10];
	logic signed [MW-1:0] m_c [9];
	logic signed [RW-1:0] r_q [3];
	logic [44:0]          fxl_q, fxh_q, fyl_q, fyh_q;
	logic [63:0]          sqx_q, sqy_q;
	logic signed [31:0]   ex_q, ey_q;
	logic [62:0]          acc_q;

	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod_s1;
	mstep_t               mstep_s1;
	logic                 mval_s1;

	logic [RW-1:0]   ux, uy, uz;
	logic [NUMW-13:0] dx, dy;
	logic [QW-1:0]   quo_x, quo_y;
	logic            fault;
	logic signed [43:0] px, py;
	logic [48:0]     term;
	logic [63:0]     acc_sum;
	logic [62:0]     acc_next;

	always_comb begin
		m_c[0] = ((MW'(qp_q[0]) + MW'(qp_q[3])) <<< 1) - ONE_Q;
		m_c[1] = (MW'(qp_q[4]) - MW'(qp_q[9])) <<< 1;
		m_c[2] = (MW'(qp_q[8]) + MW'(qp_q[5])) <<< 1;
		m_c[3] = (MW'(qp_q[4]) + MW'(qp_q[9])) <<< 1;
		m_c[4] = ((MW'(qp_q[1]) + MW'(qp_q[3])) <<< 1) - ONE_Q;
		m_c[5] = (MW'(qp_q[6]) - MW'(qp_q[7])) <<< 1;
		m_c[6] = (MW'(qp_q[5]) - MW'(qp_q[8])) <<< 1;
		m_c[7] = (MW'(qp_q[7]) + MW'(qp_q[6])) <<< 1;
		m_c[8] = ((MW'(qp_q[2]) + MW'(qp_q[3])) <<< 1) - ONE_Q;
	end

	assign ux = mag_r(r_q[0]);
	assign uy = mag_r(r_q[1]);
	assign uz = mag_r(r_q[2]);
	assign fault = (r_q[2] == '0);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mstep)
			M_XX: begin mul_a = MW'(quat_x); mul_b = MW'(quat_x); end
			M_YY: begin mul_a = MW'(quat_y); mul_b = MW'(quat_y); end
			M_ZZ: begin mul_a = MW'(quat_z); mul_b = MW'(quat_z); end
			M_WW: begin mul_a = MW'(quat_w); mul_b = MW'(quat_w); end
			M_XY: begin mul_a = MW'(quat_x); mul_b = MW'(quat_y); end
			M_XZ: begin mul_a = MW'(quat_x); mul_b = MW'(quat_z); end
			M_YZ: begin mul_a = MW'(quat_y); mul_b = MW'(quat_z); end
			M_WX: begin mul_a = MW'(quat_w); mul_b = MW'(quat_x); end
			M_WY: begin mul_a = MW'(quat_w); mul_b = MW'(quat_y); end
			M_WZ: begin mul_a = MW'(quat_w); mul_b = MW'(quat_z); end
			M_R00: begin mul_a = MW'(p_q[0]); mul_b = m_c[0]; end
			M_R01: begin mul_a = MW'(p_q[1]); mul_b = m_c[1]; end
			M_R02: begin mul_a = MW'(p_q[2]); mul_b = m_c[2]; end
			M_R10: begin mul_a = MW'(p_q[0]); mul_b = m_c[3]; end
			M_R11: begin mul_a = MW'(p_q[1]); mul_b = m_c[4]; end
			M_R12: begin mul_a = MW'(p_q[2]); mul_b = m_c[5]; end
			M_R20: begin mul_a = MW'(p_q[0]); mul_b = m_c[6]; end
			M_R21: begin mul_a = MW'(p_q[1]); mul_b = m_c[7]; end
			M_R22: begin mul_a = MW'(p_q[2]); mul_b = m_c[8]; end
			M_FXL: begin mul_a = MW'(focal_length); mul_b = MW'(ux[28:0]); end
			M_FXH: begin mul_a = MW'(focal_length); mul_b = MW'(ux[RW-1:29]); end
			M_FYL: begin mul_a = MW'(focal_length); mul_b = MW'(uy[28:0]); end
			M_FYH: begin mul_a = MW'(focal_length); mul_b = MW'(uy[RW-1:29]); end
			M_SQX: begin mul_a = MW'(ex_q); mul_b = MW'(ex_q); end
			M_SQY: begin mul_a = MW'(ey_q); mul_b = MW'(ey_q); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mval_s1 <= 1'b0;
			acc_q   <= '0;
		end else begin
			mval_s1 <= cmd.mul_en;
			if (cmd.out_load) begin
				acc_q <= last_q ? '0 : acc_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= mul_a * mul_b;
		mstep_s1 <= cmd.mstep;
		if (cmd.load_in) begin
			p_q[0]   <= obj_x;
			p_q[1]   <= obj_y;
			p_q[2]   <= obj_z;
			meas_x_q <= meas_x;
			meas_y_q <= meas_y;
			last_q   <= last_point;
			r_q[0]   <= {{(RW-48){trans_x[31]}}, trans_x, 16'b0};
			r_q[1]   <= {{(RW-48){trans_y[31]}}, trans_y, 16'b0};
			r_q[2]   <= {{(RW-48){trans_z[31]}}, trans_z, 16'b0};
		end
		if (mval_s1) begin
			case (mstep_s1)
				M_XX, M_YY, M_ZZ, M_WW, M_XY, M_XZ, M_YZ, M_WX, M_WY, M_WZ: begin
					qp_q[mstep_s1[3:0]] <= prod_s1[31:0];
				end
				M_R00, M_R01, M_R02: r_q[0] <= r_q[0] + RW'(prod_s1 >>> 12);
				M_R10, M_R11, M_R12: r_q[1] <= r_q[1] + RW'(prod_s1 >>> 12);
				M_R20, M_R21, M_R22: r_q[2] <= r_q[2] + RW'(prod_s1 >>> 12);
				M_FXL: fxl_q <= prod_s1[44:0];
				M_FXH: fxh_q <= prod_s1[44:0];
				M_FYL: fyl_q <= prod_s1[44:0];
				M_FYH: fyh_q <= prod_s1[44:0];
				M_SQX: sqx_q <= prod_s1[63:0];
				M_SQY: sqy_q <= prod_s1[63:0];
				default: ;
			endcase
		end
		if (cmd.err_load) begin
			ex_q <= fault ? '0 : sat32(44'(meas_x_q) - px);
			ey_q <= fault ? '0 : sat32(44'(meas_y_q) - py);
		end
		if (cmd.out_load) begin
			err_x       <= ex_q;
			err_y       <= ey_q;
			sum_sq_err  <= acc_next;
			set_done    <= last_q;
			depth_fault <= fault;
		end
	end

	assign dx = ((NUMW-12)'(fxh_q) << 29) + (NUMW-12)'(fxl_q);
	assign dy = ((NUMW-12)'(fyh_q) << 29) + (NUMW-12)'(fyl_q);

	pre_div u_div (
		.clk   (clk),
		.load  (cmd.div_load),
		.step  (cmd.div_step),
		.num_a ({dx, 12'b0}),
		.num_b ({dy, 12'b0}),
		.den   (uz),
		.quo_a (quo_x),
		.quo_b (quo_y)
	);

	// projection is negative when x and z share a sign (camera looks down -z)
	assign px = (r_q[0][RW-1] == r_q[2][RW-1]) ? -44'(quo_x) : 44'(quo_x);
	assign py = (r_q[1][RW-1] == r_q[2][RW-1]) ? -44'(quo_y) : 44'(quo_y);

	assign term     = 49'((65'(sqx_q) + 65'(sqy_q)) >> 16);
	assign acc_sum  = 64'(acc_q) + 64'(term);
	assign acc_next = acc_sum[63] ? SUM_MAX : acc_sum[62:0];

endmodule

>>> rtl/core/pre_ctrl.sv
// controller: sequences multiplier steps, divider and output register
// depends on pre_pkg
module pre_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output pre_pkg::cmd_t cmd
);
	import pre_pkg::*;

	state_t            state_q, state_d;
	mstep_t            mstep_q;
	logic [DCW-1:0]    cnt_q;
	logic              out_valid_q;
	logic              slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (in_valid) state_d = S_MUL;
			S_MUL:   if (mstep_q == M_FYH) state_d = S_DRAIN;
			S_DRAIN: state_d = S_DIVLD;
			S_DIVLD: state_d = S_DIV;
			S_DIV:   if (cnt_q == DCW'(DIVN - 1)) state_d = S_ERR;
			S_ERR:   state_d = S_SQ;
			S_SQ:    if (mstep_q == M_SQY) state_d = S_SQD;
			S_SQD:   state_d = S_FIN;
			S_FIN:   if (slot_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.mstep = mstep_q;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			S_MUL, S_SQ: cmd.mul_en = 1'b1;
			S_DIVLD: cmd.div_load = 1'b1;
			S_DIV:   cmd.div_step = 1'b1;
			S_ERR:   cmd.err_load = 1'b1;
			S_FIN:   cmd.out_load = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mstep_q     <= M_XX;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE:  mstep_q <= M_XX;
				S_MUL, S_SQ: mstep_q <= mstep_t'(mstep_q + 5'd1);
				S_ERR:   mstep_q <= M_SQX;
				default: ;
			endcase
			cnt_q <= (state_q == S_DIV) ? DCW'(cnt_q + 1'b1) : '0;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> rtl/core/point_reprojection_error.sv
// point reprojection error: a new point is taken only after the previous one has
// reached the output register; the 86-step serial divider does most of the work,
// the rest is 25 steps of the single shared multiplier
// the next input is taken while a result waits in the output register
// arst_n clears the controller and the error sum, configuration returns to defaults
// top level: configuration registers, pre_ctrl and pre_dp; depends on pre_pkg
module point_reprojection_error (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] obj_x,
	input  logic signed [31:0] obj_y,
	input  logic signed [31:0] obj_z,
	input  logic signed [31:0] meas_x,
	input  logic signed [31:0] meas_y,
	input  logic               last_point,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] err_x,
	output logic signed [31:0] err_y,
	output logic [62:0]        sum_sq_err,
	output logic               set_done,
	output logic               depth_fault
);
	import pre_pkg::*;

	logic signed [15:0] quat_x_q, quat_y_q, quat_z_q, quat_w_q;
	logic signed [31:0] trans_x_q, trans_y_q, trans_z_q;
	logic [15:0]        focal_q;
	cmd_t               cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_x_q  <= '0;
			quat_y_q  <= '0;
			quat_z_q  <= '0;
			quat_w_q  <= 16'sd16384;
			trans_x_q <= '0;
			trans_y_q <= '0;
			trans_z_q <= '0;
			focal_q   <= 16'd6400;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_QUAT_X:  quat_x_q  <= cfg_data[15:0];
				CFG_QUAT_Y:  quat_y_q  <= cfg_data[15:0];
				CFG_QUAT_Z:  quat_z_q  <= cfg_data[15:0];
				CFG_QUAT_W:  quat_w_q  <= cfg_data[15:0];
				CFG_TRANS_X: trans_x_q <= cfg_data;
				CFG_TRANS_Y: trans_y_q <= cfg_data;
				CFG_TRANS_Z: trans_z_q <= cfg_data;
				CFG_FOCAL:   focal_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	pre_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	pre_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.quat_x       (quat_x_q),
		.quat_y       (quat_y_q),
		.quat_z       (quat_z_q),
		.quat_w       (quat_w_q),
		.trans_x      (trans_x_q),
		.trans_y      (trans_y_q),
		.trans_z      (trans_z_q),
		.focal_length (focal_q),
		.obj_x        (obj_x),
		.obj_y        (obj_y),
		.obj_z        (obj_z),
		.meas_x       (meas_x),
		.meas_y       (meas_y),
		.last_point   (last_point),
		.err_x        (err_x),
		.err_y        (err_y),
		.sum_sq_err   (sum_sq_err),
		.set_done     (set_done),
		.depth_fault  (depth_fault)
	);

endmodule

>>> rtl/core/pre_chk.sv
// port-level checker for point_reprojection_error, attached by bind
// depends on assert_macros.svh
`include "assert_macros.svh"
module pre_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] err_x,
	input logic signed [31:0] err_y,
	input logic               depth_fault
);

	// a stalled result stays offered
	`PRE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	// one item at a time: input closes after a transaction
	`PRE_ASSERT_NEXT(a_in_close, in_valid && in_ready, !in_ready, "input open during work")
	// zero depth gives zero error
	`PRE_ASSERT(a_fault_zero, !(out_valid && depth_fault) || (err_x == 0 && err_y == 0), "nonzero error on depth fault")
	// a new result appears as the controller returns to idle
	`PRE_ASSERT(a_rose_idle, !$rose(out_valid) || in_ready, "result loaded while busy")

endmodule

bind point_reprojection_error pre_chk u_pre_chk (.*);
